// ===== rtl/core/unid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unid_pkg
// Shared types and constants for the unique id set store.
// ----------------------------------------------------------------------------
package unid_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned ID_W         = 32;
	localparam int unsigned COUNT_OUT_W  = 5;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_DEL = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [ID_W-1:0] EMPTY_ID = '1;

	// one queued command, already screened by the front end
	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] id;
		logic            reject;
	} unid_item_t;

endpackage

// ===== rtl/core/unique_id_set_store.sv =====
`timescale 1ns / 1ps
// an accepted item is held in the queue, then in the lookup register, then in
//   the result register; a new lookup waits for the commit of the last item in
//   the cell array, which holds one item at a time
// the queue takes up to 2 further items while the engine or output stalls
// reset: asynchronous, active low; empties the set and all handshake state
// ----------------------------------------------------------------------------
// unique_id_set_store
// Bounded set of distinct signed ids kept in insertion order, with add and
// delete-with-compaction commands answered by status and member count.
// ----------------------------------------------------------------------------
module unique_id_set_store import unid_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic signed [ID_W-1:0] id,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   status,
	output logic [COUNT_OUT_W-1:0] member_count
);

	logic       wr_en;
	unid_item_t wr_item;
	logic       q_full;
	logic       rd_en;
	logic       rd_valid;
	unid_item_t rd_item;

	unid_front u_front (
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.id       (id),
		.wr_en    (wr_en),
		.wr_item  (wr_item),
		.q_full   (q_full)
	);

	unid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_item  (wr_item),
		.full     (q_full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_item  (rd_item)
	);

	unid_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (rd_valid),
		.rd_item      (rd_item),
		.rd_en        (rd_en),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.member_count (member_count)
	);

endmodule

// ===== rtl/core/unid_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unid_front
// Input side: takes items and marks those that the engine must refuse.
// ----------------------------------------------------------------------------
module unid_front import unid_pkg::*; (
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic signed [ID_W-1:0] id,
	output logic                   wr_en,
	output unid_item_t             wr_item,
	input  logic                   q_full
);

	logic reject;

	// add of the empty marker, or delete of a negative id
	always_comb begin
		case (kind)
			KIND_ADD: reject = (id == EMPTY_ID);
			KIND_DEL: reject = id[ID_W-1];
			default:  reject = 1'b1;
		endcase
	end

	assign in_ready = arst_n && !q_full;
	assign wr_en    = in_valid && in_ready;

	always_comb begin
		wr_item        = '0;
		wr_item.kind   = kind;
		wr_item.id     = id;
		wr_item.reject = reject;
	end

endmodule

// ===== rtl/core/unid_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unid_queue
// Short item queue between the front end and the set engine.
// ----------------------------------------------------------------------------
module unid_queue import unid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  unid_item_t wr_item,
	output logic       full,
	input  logic       rd_en,
	output logic       rd_valid,
	output unid_item_t rd_item
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	unid_item_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     fill_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (fill_q == CW'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/unid_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unid_engine
// Set storage: parallel lookup over all cells, then add or delete with
// compaction, and the result register.
// ----------------------------------------------------------------------------
module unid_engine import unid_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_valid,
	input  unid_item_t             rd_item,
	output logic                   rd_en,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   status,
	output logic [COUNT_OUT_W-1:0] member_count
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [ID_W-1:0]     cell_q [CAPACITY];
	logic [CW-1:0]       count_q;

	logic                valid_s1;
	unid_item_t          item_s1;
	logic [CAPACITY-1:0] match_s1;

	logic                out_valid_q;
	logic                status_q;
	logic [CW-1:0]       count_out_q;

	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] shift_en;
	logic                commit;
	logic                hit;
	logic                full;
	logic                add_ok;
	logic                del_ok;
	logic [CW-1:0]       count_nxt;
	logic [CW+COUNT_OUT_W-1:0] count_ext;

	// one item in flight: lookup, then commit once the result register is free
	assign rd_en  = rd_valid && !valid_s1;
	assign commit = valid_s1 && (!out_valid_q || out_ready);

	// compare against held entries only
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			match[k] = (cell_q[k] == rd_item.id) && (CW'(k) < count_q);
		end
	end

	// every cell at or above the hit takes its upper neighbor
	always_comb begin
		logic run;
		run = 1'b0;
		for (int k = 0; k < CAPACITY; k++) begin
			run         = run | match_s1[k];
			shift_en[k] = run;
		end
	end

	assign hit    = |match_s1;
	assign full   = (count_q == CW'(CAPACITY));
	assign add_ok = (item_s1.kind == KIND_ADD) && !item_s1.reject && !hit && !full;
	assign del_ok = (item_s1.kind == KIND_DEL) && !item_s1.reject && hit;

	always_comb begin
		count_nxt = count_q;
		if (add_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (del_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [ID_W-1:0] upper;
		if (k + 1 < CAPACITY) begin : g_mid
			assign upper = cell_q[k+1];
		end else begin : g_top
			assign upper = EMPTY_ID;
		end

		always_ff @(posedge clk) begin
			if (commit && add_ok && (count_q == CW'(k))) begin
				cell_q[k] <= item_s1.id;
			end else if (commit && del_ok && shift_en[k]) begin
				cell_q[k] <= upper;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			item_s1  <= rd_item;
			match_s1 <= match;
		end
		if (commit) begin
			status_q    <= (add_ok || del_ok) ? STATUS_OK : STATUS_ERR;
			count_out_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// count is reported in its low bits
	assign count_ext    = {{COUNT_OUT_W{1'b0}}, count_out_q};
	assign member_count = count_ext[COUNT_OUT_W-1:0];
	assign status       = status_q;
	assign out_valid    = out_valid_q;

endmodule

// ===== rtl/core/unid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unid_checker
// Port-level checks for the unique id set store.
// ----------------------------------------------------------------------------
module unid_checker import unid_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   status,
	input logic [COUNT_OUT_W-1:0] member_count
);

	logic [7:0]             pending_q;
	logic [COUNT_OUT_W:0]   last_q;
	logic                   in_acc;
	logic                   out_acc;
	logic [COUNT_OUT_W:0]   cur;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cur     = {1'b0, member_count};

	// items taken but not yet answered, and the last reported count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			last_q    <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pending_q <= pending_q + 8'd1;
				2'b01:   pending_q <= pending_q - 8'd1;
				default: pending_q <= pending_q;
			endcase
			if (out_acc) begin
				last_q <= cur;
			end
		end
	end

	a_no_spurious_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result item without a pending input item");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(member_count))
		else $error("stalled result item changed");

	a_error_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && status == STATUS_ERR && CAPACITY < 32 |-> cur == last_q)
		else $error("failed command changed the member count");

	a_ok_steps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && status == STATUS_OK && CAPACITY < 32
		|-> cur == last_q + 6'd1 || cur + 6'd1 == last_q)
		else $error("successful command did not move the count by one");

endmodule

bind unique_id_set_store unid_checker #(.CAPACITY(CAPACITY)) u_unid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.member_count (member_count)
);

// ===== dv/tb_unique_id_set_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_id_set_store
// Self-checking bench for the unique id set store. A table of directed items
// covers the refused cases, a full set and compaction on delete. Random add
// and delete items follow, drawn mostly from a small id pool so the set fills,
// empties and sees duplicates. Each result is checked against its table row or
// a local set model, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_unique_id_set_store;
	import unid_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned ITEMS_PER_PHASE = 400;

	typedef struct {
		logic                   kind;
		logic [ID_W-1:0]        id;
		bit                     typed;
		logic                   status;
		logic [COUNT_OUT_W-1:0] count;
	} dir_row_t;

	typedef struct {
		logic                   status;
		logic [COUNT_OUT_W-1:0] count;
	} answer_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   in_kind;
	logic signed [ID_W-1:0] in_id;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   out_status;
	logic [COUNT_OUT_W-1:0] out_count;

	// local copy of the set
	logic [ID_W-1:0] held_ids [DEF_CAPACITY];
	int unsigned     held_total;

	answer_t  answers_due [$];
	dir_row_t dir_rows [$];

	int          send_idle_pct;
	int          recv_stall_pct;
	int          mismatches;
	int unsigned quiet_cycles;

	unique_id_set_store #(
		.CAPACITY(DEF_CAPACITY)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (in_kind),
		.id          (in_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (out_status),
		.member_count(out_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_set();
		for (int i = 0; i < DEF_CAPACITY; i++) held_ids[i] = EMPTY_ID;
		held_total = 0;
	endtask

	// add appends, delete removes and closes the gap
	task automatic apply_set_op(input logic k, input logic [ID_W-1:0] v, output logic st);
		int slot;
		slot = -1;
		for (int i = 0; i < held_total; i++)
			if (slot < 0 && held_ids[i] == v) slot = i;
		st = STATUS_ERR;
		if (k == KIND_ADD) begin
			if (v != EMPTY_ID && slot < 0 && held_total < DEF_CAPACITY) begin
				held_ids[held_total] = v;
				held_total++;
				st = STATUS_OK;
			end
		end else if (!v[ID_W-1] && slot >= 0) begin
			for (int i = slot; i + 1 < held_total; i++) held_ids[i] = held_ids[i + 1];
			held_ids[held_total - 1] = EMPTY_ID;
			held_total--;
			st = STATUS_OK;
		end
	endtask

	function automatic void add_row(logic k, logic [ID_W-1:0] v, bit typed,
			logic st = STATUS_OK, logic [COUNT_OUT_W-1:0] cnt = '0);
		dir_row_t r;
		r.kind = k;
		r.id = v;
		r.typed = typed;
		r.status = st;
		r.count = cnt;
		dir_rows.push_back(r);
	endfunction

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic drive_item(input logic k, input logic [ID_W-1:0] v, input bit typed,
			input logic tst, input logic [COUNT_OUT_W-1:0] tcnt);
		logic    st;
		answer_t a;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_kind <= k;
		in_id <= v;
		do @(posedge clk); while (!in_ready);
		apply_set_op(k, v, st);
		if (typed) begin
			a.status = tst;
			a.count = tcnt;
		end else begin
			a.status = st;
			a.count = held_total[COUNT_OUT_W-1:0];
		end
		answers_due.push_back(a);
		@(negedge clk);
	endtask

	task automatic wait_for_answers();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pick_random_op(input int add_pct, output logic k, output logic [ID_W-1:0] v);
		int r;
		k = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_DEL;
		r = $urandom_range(0, 99);
		if (r < 65)
			v = $urandom_range(0, 23);
		else if (r < 77)
			v = $urandom;
		else if (r < 82)
			v = EMPTY_ID;
		else if (r < 90) begin
			case ($urandom_range(0, 3))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = '0;
				default: v = {1'b1, (ID_W-1)'($urandom)};
			endcase
		end else if (held_total != 0)
			v = held_ids[$urandom_range(0, held_total - 1)];
		else
			v = $urandom_range(0, 23);
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					note_mismatch($sformatf("result with nothing pending: status %0b count %0d",
						out_status, out_count));
				end else begin
					a = answers_due.pop_front();
					if (out_status !== a.status)
						note_mismatch($sformatf("status exp %0b got %0b", a.status, out_status));
					if (out_count !== a.count)
						note_mismatch($sformatf("member_count exp %0d got %0d", a.count, out_count));
				end
			end
		end
	end

	initial begin
		logic            k;
		logic [ID_W-1:0] v;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_kind = KIND_ADD;
		in_id = '0;
		clear_set();

		// refused items on an empty set, then extremes and negative ids
		add_row(KIND_DEL, 32'd5, 1, STATUS_ERR, 5'd0);
		add_row(KIND_ADD, EMPTY_ID, 1, STATUS_ERR, 5'd0);
		add_row(KIND_DEL, -32'sd5, 1, STATUS_ERR, 5'd0);
		add_row(KIND_ADD, 32'h7fff_ffff, 1, STATUS_OK, 5'd1);
		add_row(KIND_ADD, 32'h8000_0000, 1, STATUS_OK, 5'd2);
		add_row(KIND_ADD, 32'h7fff_ffff, 1, STATUS_ERR, 5'd2);
		add_row(KIND_DEL, 32'h8000_0000, 1, STATUS_ERR, 5'd2);
		add_row(KIND_ADD, 32'd0, 1, STATUS_OK, 5'd3);
		for (int i = 1; i <= 13; i++) add_row(KIND_ADD, i, 0);
		// set is full here
		add_row(KIND_ADD, 32'd100, 1, STATUS_ERR, 5'd16);
		add_row(KIND_DEL, 32'd5, 0);
		add_row(KIND_DEL, 32'h7fff_ffff, 0);
		add_row(KIND_DEL, 32'd999, 0);
		add_row(KIND_DEL, EMPTY_ID, 0);
		add_row(KIND_ADD, 32'd5, 0);
		add_row(KIND_DEL, 32'd5, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			drive_item(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].typed,
				dir_rows[i].status, dir_rows[i].count);
		wait_for_answers();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// alternate between filling and emptying the set
				pick_random_op(((n / 50) % 2) ? 30 : 75, k, v);
				drive_item(k, v, 0, STATUS_OK, '0);
				if ($urandom_range(0, 99) == 0) wait_for_answers();
			end
			wait_for_answers();
		end

		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/unid_pkg.sv
rtl/core/unid_front.sv
rtl/core/unid_queue.sv
rtl/core/unid_engine.sv
rtl/core/unique_id_set_store.sv
rtl/core/unid_checker.sv
dv/tb_unique_id_set_store.sv
